// ===== sv/hsv2rgb_pkg.sv =====
// Shared constants, widths and the hue sector type for the HSV to RGB converter.
// No dependencies; the interfaces and the core import this package.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

   localparam int HUE_W = 16;
   localparam int PCT_IN_W = 8;
   localparam int PCT_W = 7;

   localparam int HUE_FULL = 360;
   localparam int PCT_FULL = 100;
   localparam int SECTOR_DEG = 60;
   localparam int FRAC_SCALE = SECTOR_DEG * PCT_FULL;

   // Reciprocal constants: floor(x / d) == (x * M) >> K over the ranges used here.
   localparam logic [13:0] RECIP_360 = 14'd11651;   // K = 22, x < 65536
   localparam logic [10:0] RECIP_60 = 11'd1093;     // K = 16, x < 360
   localparam logic [19:0] RECIP_6000 = 20'd715828; // K = 32, x <= 600000
   localparam logic [13:0] RECIP_100 = 14'd10486;   // K = 20, x <= 10000

   typedef enum logic [2:0] {
      SEC_RED = 3'd0,
      SEC_YELLOW = 3'd1,
      SEC_GREEN = 3'd2,
      SEC_CYAN = 3'd3,
      SEC_BLUE = 3'd4,
      SEC_MAGENTA = 3'd5
   } sector_type;

endpackage

// ===== sv/hsv2rgb_if.sv =====
// Valid/ready channel interfaces for HSV requests and RGB responses.
// Depends on hsv2rgb_pkg for the field widths.
`timescale 1ns / 1ps

interface hsv2rgb_req_if import hsv2rgb_pkg::*; ();
   logic valid;
   logic ready;
   logic [HUE_W-1:0] hue;
   logic [PCT_IN_W-1:0] saturation;
   logic [PCT_IN_W-1:0] brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink (input valid, input hue, input saturation, input brightness,
                 output ready);
endinterface

interface hsv2rgb_rsp_if import hsv2rgb_pkg::*; ();
   logic valid;
   logic ready;
   logic [PCT_W-1:0] red;
   logic [PCT_W-1:0] green;
   logic [PCT_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== sv/hsv_to_rgb_converter_core.sv =====
// Top level of the HSV to RGB converter: a six-stage pipeline with per-stage valid bits.
// Depends on hsv2rgb_pkg and the channel interfaces in hsv2rgb_if.sv.
`timescale 1ns / 1ps

// How to use this block:
// The req_chan channel carries one HSV color per beat (hue in degrees, saturation and
// brightness in percent). The rsp_chan channel returns one RGB color per beat, each
// channel in percent from 0 to 100. A beat moves when valid and ready are both high.
// Hue is reduced modulo 360; saturation and brightness above 100 are treated as 100.
// A beat accepted into stage 1 moves through stages 2 to 5 into the output register of
// stage 6, which drives rsp_chan; a stalled receiver holds it where it is.
// Throughput is one color per cycle while the response side does not stall. The stages
// are hue quotient by 360 with the percentage clamp, hue reduction, sector split, small
// products, the two long products, and the reciprocal divisions with the channel select.
// Each stage holds its own valid bit and moves forward when the stage ahead is empty
// or moving, so a stalled receiver fills the bubbles first and then holds req_chan
// ready low; no beat is dropped or repeated. The output register keeps its beat
// steady until it is taken.
// Reset is synchronous and active high. It empties every stage; no beat is in flight
// afterwards and the block is ready at once. There is no configuration and no state
// carried from one color to the next.
module hsv_to_rgb_converter_core import hsv2rgb_pkg::*; (
   input logic clock,
   input logic reset,
   hsv2rgb_req_if.sink req_chan,
   hsv2rgb_rsp_if.source rsp_chan
);

   // Stage valid bits and load enables.
   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff;
   logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy;

   // Stage 1: quotient of hue by 360, limited percentages.
   logic [HUE_W-1:0] s1_hue_ff;
   logic [7:0] s1_quo_ff, s1_quo_in;
   logic [PCT_W-1:0] s1_sat_ff, s1_sat_in, s1_val_ff, s1_val_in;
   logic [29:0] s1_prod;

   // Stage 2: hue reduced to 0..359.
   logic [8:0] s2_h_ff, s2_h_in;
   logic [PCT_W-1:0] s2_sat_ff, s2_val_ff;
   logic [15:0] s2_wrap;
   logic [15:0] s2_diff;

   // Stage 3: sector and offset inside the sector.
   sector_type s3_sec_ff, s3_sec_in;
   logic [5:0] s3_r_ff, s3_r_in;
   logic [PCT_W-1:0] s3_sat_ff, s3_val_ff;
   logic [19:0] s3_prod;
   logic [8:0] s3_base;
   logic [8:0] s3_diff;

   // Stage 4: short products.
   logic [12:0] s4_rs_ff, s4_rs_in, s4_rt_ff, s4_rt_in;
   logic [13:0] s4_pn_ff, s4_pn_in;
   sector_type s4_sec_ff;
   logic [PCT_W-1:0] s4_val_ff;
   logic [5:0] s4_rinv;

   // Stage 5: long products for q and t.
   logic [19:0] s5_qn_ff, s5_qn_in, s5_tn_ff, s5_tn_in;
   logic [13:0] s5_pn_ff;
   sector_type s5_sec_ff;
   logic [PCT_W-1:0] s5_val_ff;

   // Stage 6: divisions by reciprocal and channel select into the output register.
   logic [39:0] s6_qprod, s6_tprod;
   logic [27:0] s6_pprod;
   logic [PCT_W-1:0] s6_q, s6_t, s6_p;
   logic [PCT_W-1:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   // A stage may load when it is empty or its content moves on this cycle.
   assign s6_rdy = !s6_vld_ff || rsp_chan.ready;
   assign s5_rdy = !s5_vld_ff || s6_rdy;
   assign s4_rdy = !s4_vld_ff || s5_rdy;
   assign s3_rdy = !s3_vld_ff || s4_rdy;
   assign s2_rdy = !s2_vld_ff || s3_rdy;
   assign s1_rdy = !s1_vld_ff || s2_rdy;
   assign req_chan.ready = s1_rdy;

   always_comb begin
      // Stage 1 logic.
      s1_prod = req_chan.hue * RECIP_360;
      s1_quo_in = s1_prod[29:22];
      s1_sat_in = (req_chan.saturation > PCT_IN_W'(PCT_FULL)) ? PCT_W'(PCT_FULL)
                                                             : req_chan.saturation[PCT_W-1:0];
      s1_val_in = (req_chan.brightness > PCT_IN_W'(PCT_FULL)) ? PCT_W'(PCT_FULL)
                                                             : req_chan.brightness[PCT_W-1:0];

      // Stage 2 logic: the quotient is exact, so the difference is below 360.
      s2_wrap = 16'(s1_quo_ff) * 16'(HUE_FULL);
      s2_diff = s1_hue_ff - s2_wrap;
      s2_h_in = s2_diff[8:0];

      // Stage 3 logic.
      s3_prod = 20'(s2_h_ff) * 20'(RECIP_60);
      s3_sec_in = sector_type'(s3_prod[18:16]);
      s3_base = 9'(s3_prod[18:16]) * 9'(SECTOR_DEG);
      s3_diff = s2_h_ff - s3_base;
      s3_r_in = s3_diff[5:0];

      // Stage 4 logic.
      s4_rinv = 6'(SECTOR_DEG) - s3_r_ff;
      s4_rs_in = 13'(s3_r_ff) * 13'(s3_sat_ff);
      s4_rt_in = 13'(s4_rinv) * 13'(s3_sat_ff);
      s4_pn_in = 14'(s3_val_ff) * 14'(7'(PCT_FULL) - s3_sat_ff);

      // Stage 5 logic.
      s5_qn_in = 20'(s4_val_ff) * 20'(13'(FRAC_SCALE) - s4_rs_ff);
      s5_tn_in = 20'(s4_val_ff) * 20'(13'(FRAC_SCALE) - s4_rt_ff);

      // Stage 6 logic.
      s6_qprod = 40'(s5_qn_ff) * 40'(RECIP_6000);
      s6_tprod = 40'(s5_tn_ff) * 40'(RECIP_6000);
      s6_pprod = 28'(s5_pn_ff) * 28'(RECIP_100);
      s6_q = s6_qprod[38:32];
      s6_t = s6_tprod[38:32];
      s6_p = s6_pprod[26:20];

      case (s5_sec_ff)
         SEC_RED: begin
            red_in = s5_val_ff; green_in = s6_t; blue_in = s6_p;
         end
         SEC_YELLOW: begin
            red_in = s6_q; green_in = s5_val_ff; blue_in = s6_p;
         end
         SEC_GREEN: begin
            red_in = s6_p; green_in = s5_val_ff; blue_in = s6_t;
         end
         SEC_CYAN: begin
            red_in = s6_p; green_in = s6_q; blue_in = s5_val_ff;
         end
         SEC_BLUE: begin
            red_in = s6_t; green_in = s6_p; blue_in = s5_val_ff;
         end
         default: begin
            red_in = s5_val_ff; green_in = s6_p; blue_in = s6_q;
         end
      endcase
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
      end else begin
         if (s1_rdy) s1_vld_ff <= req_chan.valid;
         if (s2_rdy) s2_vld_ff <= s1_vld_ff;
         if (s3_rdy) s3_vld_ff <= s2_vld_ff;
         if (s4_rdy) s4_vld_ff <= s3_vld_ff;
         if (s5_rdy) s5_vld_ff <= s4_vld_ff;
         if (s6_rdy) s6_vld_ff <= s5_vld_ff;
      end
   end

   // Payload registers; they load with their stage and need no reset.
   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_hue_ff <= req_chan.hue;
         s1_quo_ff <= s1_quo_in;
         s1_sat_ff <= s1_sat_in;
         s1_val_ff <= s1_val_in;
      end
      if (s2_rdy) begin
         s2_h_ff <= s2_h_in;
         s2_sat_ff <= s1_sat_ff;
         s2_val_ff <= s1_val_ff;
      end
      if (s3_rdy) begin
         s3_sec_ff <= s3_sec_in;
         s3_r_ff <= s3_r_in;
         s3_sat_ff <= s2_sat_ff;
         s3_val_ff <= s2_val_ff;
      end
      if (s4_rdy) begin
         s4_rs_ff <= s4_rs_in;
         s4_rt_ff <= s4_rt_in;
         s4_pn_ff <= s4_pn_in;
         s4_sec_ff <= s3_sec_ff;
         s4_val_ff <= s3_val_ff;
      end
      if (s5_rdy) begin
         s5_qn_ff <= s5_qn_in;
         s5_tn_ff <= s5_tn_in;
         s5_pn_ff <= s4_pn_ff;
         s5_sec_ff <= s4_sec_ff;
         s5_val_ff <= s4_val_ff;
      end
      if (s6_rdy) begin
         red_ff <= red_in;
         green_ff <= green_in;
         blue_ff <= blue_in;
      end
   end

   assign rsp_chan.valid = s6_vld_ff;
   assign rsp_chan.red = red_ff;
   assign rsp_chan.green = green_ff;
   assign rsp_chan.blue = blue_ff;

   // The reduced hue must always land inside one turn.
   a_hue_reduced: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> s2_h_ff < 9'(HUE_FULL))
      else $error("reduced hue out of range");

   // Sector split must give a legal sector and an offset below one sector width.
   a_sector_split: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff |-> (s3_sec_ff <= SEC_MAGENTA) && (s3_r_ff < 6'(SECTOR_DEG)))
      else $error("sector split out of range");

   // Every delivered channel is a percentage.
   a_out_pct: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (red_ff <= 7'(PCT_FULL)) && (green_ff <= 7'(PCT_FULL))
                         && (blue_ff <= 7'(PCT_FULL)))
      else $error("output channel above 100");

   // Stage five, holding a beat while stage six is blocked, must not lose it.
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      s5_vld_ff && !s6_rdy |=> s5_vld_ff && $stable(s5_qn_ff))
      else $error("stalled beat lost in stage five");

endmodule

// ===== tb/hsv_to_rgb_converter_core_test.sv =====
// Testbench for the HSV to RGB converter core: directed colors, then random colors under bursty
// input and a stalling receiver, each response checked against a typed-in value or an independent predictor.
// Depends on hsv2rgb_pkg, the channel interfaces in hsv2rgb_if.sv and the converter core.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core_test import hsv2rgb_pkg::*; ();

   localparam int CLOCK_HALF_NS = 6;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_COLORS = 1250;
   // Cycles with no beat on either channel before the run is declared hung.
   localparam int IDLE_LIMIT = 2000;
   // The long receiver hold-off starts once this many responses were checked.
   localparam int HOLD_OFF_AFTER = 300;
   localparam int HOLD_OFF_CYCLES = 96;
   // The pipeline is six stages deep; the drain after the last response catches stray beats.
   localparam int DRAIN_CYCLES = 24;
   localparam int DIRECTED_ROWS = 25;

   typedef struct packed {
      logic [PCT_W-1:0] red;
      logic [PCT_W-1:0] green;
      logic [PCT_W-1:0] blue;
   } rgb_color_type;

   // One row of stimulus. When known is set, rgb holds the response typed in by hand;
   // otherwise the predictor works it out.
   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [PCT_IN_W-1:0] saturation;
      logic [PCT_IN_W-1:0] brightness;
      logic known;
      rgb_color_type rgb;
   } color_row_type;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_COIN,
      RX_SPARSE,
      RX_PERIODIC
   } rx_pattern_type;

   localparam logic KNOWN = 1'b1;
   localparam logic PREDICT = 1'b0;
   localparam rgb_color_type NO_RGB = '0;

   // Directed colors: black, greys, the six pure sector corners, hue wrap-around,
   // saturation and value clamping, and mid-sector colors in every sector.
   localparam color_row_type DIRECTED_COLORS [DIRECTED_ROWS] = '{
      '{16'd0,     8'd0,   8'd0,   KNOWN,   '{7'd0,   7'd0,   7'd0}},
      '{16'd0,     8'd0,   8'd100, KNOWN,   '{7'd100, 7'd100, 7'd100}},
      '{16'd200,   8'd0,   8'd37,  KNOWN,   '{7'd37,  7'd37,  7'd37}},
      '{16'd0,     8'd100, 8'd100, KNOWN,   '{7'd100, 7'd0,   7'd0}},
      '{16'd60,    8'd100, 8'd100, KNOWN,   '{7'd100, 7'd100, 7'd0}},
      '{16'd120,   8'd100, 8'd100, KNOWN,   '{7'd0,   7'd100, 7'd0}},
      '{16'd180,   8'd100, 8'd100, KNOWN,   '{7'd0,   7'd100, 7'd100}},
      '{16'd240,   8'd100, 8'd100, KNOWN,   '{7'd0,   7'd0,   7'd100}},
      '{16'd300,   8'd100, 8'd100, KNOWN,   '{7'd100, 7'd0,   7'd100}},
      '{16'd360,   8'd100, 8'd100, KNOWN,   '{7'd100, 7'd0,   7'd0}},
      '{16'd960,   8'd100, 8'd100, KNOWN,   '{7'd0,   7'd0,   7'd100}},
      '{16'd65520, 8'd100, 8'd100, KNOWN,   '{7'd100, 7'd0,   7'd0}},
      '{16'd0,     8'd255, 8'd255, KNOWN,   '{7'd100, 7'd0,   7'd0}},
      '{16'd0,     8'd101, 8'd50,  KNOWN,   '{7'd50,  7'd0,   7'd0}},
      '{16'd77,    8'd255, 8'd0,   KNOWN,   '{7'd0,   7'd0,   7'd0}},
      '{16'd65535, 8'd255, 8'd255, PREDICT, NO_RGB},
      '{16'd30,    8'd50,  8'd80,  PREDICT, NO_RGB},
      '{16'd90,    8'd50,  8'd80,  PREDICT, NO_RGB},
      '{16'd150,   8'd50,  8'd80,  PREDICT, NO_RGB},
      '{16'd210,   8'd50,  8'd80,  PREDICT, NO_RGB},
      '{16'd270,   8'd50,  8'd80,  PREDICT, NO_RGB},
      '{16'd330,   8'd50,  8'd80,  PREDICT, NO_RGB},
      '{16'd359,   8'd100, 8'd100, PREDICT, NO_RGB},
      '{16'd59,    8'd100, 8'd100, PREDICT, NO_RGB},
      '{16'd1,     8'd1,   8'd1,   PREDICT, NO_RGB}
   };

   logic clock = 1'b0;
   logic reset;

   hsv2rgb_req_if req_chan ();
   hsv2rgb_rsp_if rsp_chan ();

   hsv_to_rgb_converter_core DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Colors accepted by the core whose RGB beat has not come back yet, oldest first.
   rgb_color_type pending_rgb [$];
   rgb_color_type oldest_rgb;
   int failures = 0;
   int colors_checked = 0;
   int idle_cycles = 0;
   // Beats left in the current input burst before the sender pauses.
   int burst_left;

   always #(CLOCK_HALF_NS) clock = ~clock;

   // Six-sector HSV to RGB conversion in integer percent. Hue wraps at 360 degrees,
   // saturation and value clamp at 100, and the sector picks the channel order.
   function automatic rgb_color_type convert_hsv_to_rgb(logic [HUE_W-1:0] hue,
                                                        logic [PCT_IN_W-1:0] sat_in,
                                                        logic [PCT_IN_W-1:0] bri_in);
      int unsigned h;
      int unsigned s;
      int unsigned v;
      int unsigned r;
      int unsigned p;
      int unsigned q;
      int unsigned t;
      int unsigned ch [3];
      sector_type sector;
      rgb_color_type rgb;
      h = hue % HUE_FULL;
      s = (sat_in > PCT_FULL) ? PCT_FULL : sat_in;
      v = (bri_in > PCT_FULL) ? PCT_FULL : bri_in;
      sector = sector_type'(h / SECTOR_DEG);
      r = h % SECTOR_DEG;
      // p is the floor level, q falls across the sector and t rises across it.
      p = v * (PCT_FULL - s) / PCT_FULL;
      q = v * (FRAC_SCALE - r * s) / FRAC_SCALE;
      t = v * (FRAC_SCALE - (SECTOR_DEG - r) * s) / FRAC_SCALE;
      case (sector)
         SEC_RED: ch = '{v, t, p};
         SEC_YELLOW: ch = '{q, v, p};
         SEC_GREEN: ch = '{p, v, t};
         SEC_CYAN: ch = '{p, q, v};
         SEC_BLUE: ch = '{t, p, v};
         default: ch = '{v, p, q};
      endcase
      rgb.red = PCT_W'(ch[0]);
      rgb.green = PCT_W'(ch[1]);
      rgb.blue = PCT_W'(ch[2]);
      return rgb;
   endfunction

   // Offers one color and holds it until the core takes it. The expected response is
   // queued at the edge of the handshake. When the burst runs out the sender drops
   // valid for a random gap; a gap of zero keeps valid high into the next burst.
   task automatic offer_color(input color_row_type row);
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.hue <= row.hue;
      req_chan.saturation <= row.saturation;
      req_chan.brightness <= row.brightness;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      pending_rgb.push_back(row.known ? row.rgb
                                      : convert_hsv_to_rgb(row.hue, row.saturation,
                                                           row.brightness));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(0, 40);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic check_channel(input string name, input logic [PCT_W-1:0] want,
                                input logic [PCT_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   // Stimulus: reset, the directed table, then random colors. Most hues are in range,
   // some are spread over all 16 bits to exercise the wrap, and some sit on the sector
   // edges. Saturation and value mostly stay within 0..100 but now and then take any
   // 8-bit value so the clamp is hit.
   initial begin
      color_row_type row;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.hue <= '0;
      req_chan.saturation <= '0;
      req_chan.brightness <= '0;
      burst_left = $urandom_range(0, 40);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_COLORS[i]) offer_color(DIRECTED_COLORS[i]);

      for (int n = 0; n < RANDOM_COLORS; n++) begin
         row.known = PREDICT;
         row.rgb = NO_RGB;
         case ($urandom_range(0, 3))
            0: row.hue = HUE_W'($urandom_range(0, 65535));
            1: row.hue = HUE_W'($urandom_range(0, 5) * SECTOR_DEG
                                + (($urandom_range(0, 1) == 0) ? 0 : SECTOR_DEG - 1));
            default: row.hue = HUE_W'($urandom_range(0, HUE_FULL - 1));
         endcase
         row.saturation = ($urandom_range(0, 7) == 0) ? PCT_IN_W'($urandom_range(0, 255))
                                                       : PCT_IN_W'($urandom_range(0, PCT_FULL));
         row.brightness = ($urandom_range(0, 7) == 0) ? PCT_IN_W'($urandom_range(0, 255))
                                                       : PCT_IN_W'($urandom_range(0, PCT_FULL));
         offer_color(row);
      end
      req_chan.valid <= 1'b0;

      // Every accepted color must come back; the watchdog bounds this wait.
      while (pending_rgb.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Receiver: stretches of random length, each with its own ready pattern. Once, after
   // enough traffic, ready is held low for a long stretch so that the pipeline fills
   // and the core has to push back on the sender.
   initial begin
      rx_pattern_type pattern;
      int stretch;
      bit held_off;
      rsp_chan.ready <= 1'b0;
      held_off = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && colors_checked >= HOLD_OFF_AFTER) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            held_off = 1'b1;
         end
         pattern = rx_pattern_type'($urandom_range(0, 3));
         stretch = $urandom_range(8, 120);
         for (int step = 0; step < stretch; step++) begin
            case (pattern)
               RX_ALWAYS: rsp_chan.ready <= 1'b1;
               RX_COIN: rsp_chan.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_chan.ready <= ($urandom_range(0, 4) == 0);
               default: rsp_chan.ready <= (step % 3 != 2);
            endcase
            @(posedge clock);
         end
      end
   end

   // Response checker. Each RGB beat is compared channel by channel with the oldest
   // expected color; a beat with nothing expected is a failure on its own.
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_rgb.size() == 0) begin
            $display("%0t ns: unexpected beat, expected none, actual %0d/%0d/%0d",
                     $time, rsp_chan.red, rsp_chan.green, rsp_chan.blue);
            failures++;
         end else begin
            oldest_rgb = pending_rgb.pop_front();
            check_channel("red", oldest_rgb.red, rsp_chan.red);
            check_channel("green", oldest_rgb.green, rsp_chan.green);
            check_channel("blue", oldest_rgb.blue, rsp_chan.blue);
         end
         colors_checked++;
      end
   end

   // Watchdog: a run of cycles with no beat on either channel means the core hung.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: no beat for %0d cycles", $time, idle_cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule
